>>> hdl/clad_pkg.sv
// ---------------------------------------------------------------------------
// clad_pkg
// Shared types and codes for the compact list append/delete unit.
// ---------------------------------------------------------------------------
package clad_pkg;

  // field widths
  localparam int unsigned KEY_W    = 31;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned POS_W    = 4;

  // operation codes
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd2;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } state_t;

  // per-cycle strobes from the controller to every cell
  typedef struct packed {
    logic capture;    // register the match flag for the incoming key
    logic append_we;  // append commits this cycle
    logic delete_we;  // delete commits this cycle
  } cell_ctrl_t;

endpackage

>>> hdl/compact_list_append_delete_unit.sv
// ---------------------------------------------------------------------------
// compact_list_append_delete_unit
// Packed key list with append at the tail and delete of the first match.
// ---------------------------------------------------------------------------
// The match flags are registered in the cells when an item is accepted; the
// first-match chain runs in ST_APPLY, and the shift and the result register
// are written at commit. No new item is taken until the last has committed.
// A stalled output holds the commit until the result register is free.
// Reset clears the count and control; stored keys are not cleared.
module compact_list_append_delete_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [30:0] item_key, [31] zero
  input  logic [0:0]  s_tuser,   // [0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [4:0] entry_count, [8:5] position, [15:9] zero
  output logic [1:0]  m_tuser    // [1:0] status
);
  import clad_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);

  state_t               state;
  state_t               state_next;
  logic                 op;
  logic [KEY_W-1:0]     item_key;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic [STATUS_W-1:0]  status_res;
  logic [IW-1:0]        pos_res;
  logic                 accept;
  logic                 commit;
  logic                 full;
  cell_ctrl_t           ctrl;

  logic [KEY_W-1:0]     cell_key [CAPACITY];
  logic                 found    [CAPACITY+1];
  logic [IW-1:0]        pos_link [CAPACITY+1];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign commit   = (state == ST_APPLY) && (!m_tvalid || m_tready);
  assign full     = (count == CW'(CAPACITY));

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = ST_APPLY;
      ST_APPLY: if (commit) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // latch the accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= s_tuser[0];
      item_key <= s_tdata[KEY_W-1:0];
    end
  end

  // cell strobes
  always_comb begin
    ctrl.capture   = accept;
    ctrl.append_we = commit && (op == OP_APPEND) && !full;
    ctrl.delete_we = commit && (op == OP_DELETE) && found[CAPACITY];
  end

  // chain of cells
  assign found[0]    = 1'b0;
  assign pos_link[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] nbr_key;
    if (i == CAPACITY - 1) begin : g_last
      assign nbr_key = cell_key[i];
    end else begin : g_mid
      assign nbr_key = cell_key[i+1];
    end
    clad_cell #(
      .IDX (i),
      .CW  (CW),
      .IW  (IW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .cmp_key   (s_tdata[KEY_W-1:0]),
      .wr_key    (item_key),
      .count     (count),
      .found_in  (found[i]),
      .pos_in    (pos_link[i]),
      .next_key  (nbr_key),
      .key       (cell_key[i]),
      .found_out (found[i+1]),
      .pos_out   (pos_link[i+1])
    );
  end

  // result of the pending item
  always_comb begin
    status_res = STATUS_DONE;
    count_next = count;
    pos_res    = '0;
    case (op)
      OP_APPEND: begin
        if (full) begin
          status_res = STATUS_FULL;
        end else begin
          count_next = count + CW'(1);
          pos_res    = count[IW-1:0];
        end
      end
      OP_DELETE: begin
        if (found[CAPACITY]) begin
          count_next = count - CW'(1);
          pos_res    = pos_link[CAPACITY];
        end else begin
          status_res = STATUS_MISSING;
        end
      end
      default: status_res = STATUS_DONE;
    endcase
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (commit) begin
      count <= count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tuser <= status_res;
      m_tdata <= {7'd0, POS_W'(pos_res), COUNT_W'(count_next)};
    end
  end

endmodule

>>> hdl/clad_cell.sv
// ---------------------------------------------------------------------------
// clad_cell
// One list slot: holds a key, flags a match and shifts toward index zero.
// ---------------------------------------------------------------------------
module clad_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 5,
  parameter int unsigned IW  = 4
) (
  input  logic                         clk,
  input  clad_pkg::cell_ctrl_t         ctrl,
  input  logic [clad_pkg::KEY_W-1:0]   cmp_key,
  input  logic [clad_pkg::KEY_W-1:0]   wr_key,
  input  logic [CW-1:0]                count,
  input  logic                         found_in,
  input  logic [IW-1:0]                pos_in,
  input  logic [clad_pkg::KEY_W-1:0]   next_key,
  output logic [clad_pkg::KEY_W-1:0]   key,
  output logic                         found_out,
  output logic [IW-1:0]                pos_out
);
  import clad_pkg::*;

  logic held;
  logic match;
  logic first;

  // slot is part of the list while below the count
  assign held = (CW'(IDX) < count);

  // match flag, taken when the item is accepted
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      match <= held && (key == cmp_key);
    end
  end

  // first-match chain and position encoding
  assign first     = match && !found_in;
  assign found_out = found_in || match;
  assign pos_out   = pos_in | (first ? IW'(IDX) : '0);

  // key storage: append writes at the tail, delete pulls from the neighbor
  always_ff @(posedge clk) begin
    if (ctrl.append_we && (count == CW'(IDX))) begin
      key <= wr_key;
    end else if (ctrl.delete_we && found_out) begin
      key <= next_key;
    end
  end

endmodule

>>> sim/compact_list_append_delete_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// compact_list_append_delete_unit_tb
// Self-checking bench for the packed key list. A directed run walks the
// list through empty, duplicate, shift and full cases. Random phases with
// shifting append/delete mixes follow, with delete keys mostly taken from
// recent appends. Every accepted item is run through a local list model,
// and each result is checked field by field in arrival order.
// ---------------------------------------------------------------------------
module compact_list_append_delete_unit_tb;
  import clad_pkg::*;

  localparam int unsigned LIST_DEPTH   = 16;
  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned QUIET_LIMIT  = 1000;
  localparam int unsigned LONG_HOLD    = 60;

  typedef struct {
    logic             op;
    logic [KEY_W-1:0] key;
    bit               wait_drain;  // hold off until every result is back
  } list_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic [POS_W-1:0]    pos;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [30:0] item_key, [31] zero
  logic [0:0]  s_tuser = '0;   // [0] operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [4:0] entry_count, [8:5] position, [15:9] zero
  logic [1:0]  m_tuser;        // [1:0] status

  // list model state
  logic [KEY_W-1:0] key_list [LIST_DEPTH];
  int unsigned      held_keys = 0;

  list_item_t   pending_items [$];
  list_result_t expected_results [$];

  int unsigned error_count  = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap     = 0;
  int unsigned stall_left   = 0;
  int unsigned hold_left    = 0;
  bit          send_steady  = 1'b0;
  bit          recv_steady  = 1'b0;

  compact_list_append_delete_unit #(
    .CAPACITY(LIST_DEPTH)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always #1 clk = ~clk;

  // append at the tail or remove the first match, shifting later keys down
  function automatic list_result_t apply_list_op(input logic op,
                                                 input logic [KEY_W-1:0] key);
    list_result_t r;
    int           hit;
    r   = '0;
    hit = -1;
    if (op == OP_APPEND) begin
      if (held_keys >= LIST_DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        key_list[held_keys] = key;
        r.pos     = held_keys[POS_W-1:0];
        held_keys = held_keys + 1;
        r.status  = STATUS_DONE;
      end
    end else begin
      for (int i = 0; i < held_keys; i++) begin
        if (hit < 0 && key_list[i] == key) hit = i;
      end
      if (hit < 0) begin
        r.status = STATUS_MISSING;
      end else begin
        for (int i = hit; i + 1 < held_keys; i++) key_list[i] = key_list[i + 1];
        held_keys = held_keys - 1;
        r.pos     = hit[POS_W-1:0];
        r.status  = STATUS_DONE;
      end
    end
    r.count = held_keys[COUNT_W-1:0];
    return r;
  endfunction

  task automatic queue_item(input logic op, input logic [KEY_W-1:0] key,
                            input bit wait_drain);
    list_item_t it;
    it.op         = op;
    it.key        = key;
    it.wait_drain = wait_drain;
    pending_items.push_back(it);
  endtask

  // driver: presents queued items with random gaps
  always @(posedge clk) begin
    logic next_valid;
    next_valid = s_tvalid;
    if (rst) begin
      next_valid = 1'b0;
      send_gap   = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(apply_list_op(pending_items[0].op,
                                                 pending_items[0].key));
        pending_items.pop_front();
        next_valid = 1'b0;
        if ($urandom_range(0, 15) == 0) send_steady = !send_steady;
        send_gap = send_steady ? 0 : $urandom_range(0, 7);
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].wait_drain && expected_results.size() > 0)) begin
          next_valid = 1'b1;
          s_tdata <= {1'b0, pending_items[0].key};
          s_tuser <= pending_items[0].op;
        end
      end
    end
    s_tvalid <= next_valid;
  end

  // monitor: checks results and drives ready with stalls and long holds
  always @(posedge clk) begin
    list_result_t want;
    logic         next_ready;
    next_ready = m_tready;
    if (rst) begin
      next_ready = 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d count %0d position %0d",
                 m_tuser, m_tdata[4:0], m_tdata[8:5]);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (m_tuser !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, m_tuser);
            error_count++;
          end
          if (m_tdata[4:0] !== want.count) begin
            $error("entry_count: expected %0d, actual %0d", want.count, m_tdata[4:0]);
            error_count++;
          end
          if (m_tdata[8:5] !== want.pos) begin
            $error("position: expected %0d, actual %0d", want.pos, m_tdata[8:5]);
            error_count++;
          end
        end
        next_ready = 1'b0;
        if (results_seen == 200 || results_seen == 650) begin
          hold_left = LONG_HOLD;
        end else begin
          if ($urandom_range(0, 15) == 0) recv_steady = !recv_steady;
          stall_left = recv_steady ? 0 : $urandom_range(0, 7);
        end
      end
      if (!next_ready) begin
        if (hold_left > 0) hold_left--;
        else if (stall_left > 0) stall_left--;
        else next_ready = 1'b1;
      end
    end
    m_tready <= next_ready;
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** compact_list_append_delete_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus, reset and end of run
  initial begin
    logic [KEY_W-1:0] recent_keys [$];
    logic [KEY_W-1:0] key;
    logic [31:0]      word;
    logic             op;
    int unsigned      append_pct;
    int unsigned      idx;
    int unsigned      roll;

    // directed: empty delete, extremes, duplicates, shifts, fill, full
    queue_item(OP_DELETE, '0, 1'b0);
    queue_item(OP_APPEND, {KEY_W{1'b1}}, 1'b0);
    queue_item(OP_APPEND, '0, 1'b0);
    queue_item(OP_APPEND, 31'd5, 1'b0);
    queue_item(OP_APPEND, {KEY_W{1'b1}}, 1'b0);
    queue_item(OP_DELETE, {KEY_W{1'b1}}, 1'b0);  // first of two duplicates
    queue_item(OP_DELETE, {KEY_W{1'b1}}, 1'b0);  // last entry
    queue_item(OP_DELETE, '0, 1'b0);             // head, shifts the rest
    for (int i = 0; i < LIST_DEPTH - 1; i++) begin
      queue_item(OP_APPEND, 31'h1 << (i * 2), 1'b0);
    end
    queue_item(OP_APPEND, 31'h2AAA_5555, 1'b0);  // list is full

    // random phases with a changing append/delete mix
    append_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        roll       = $urandom_range(0, 2);
        append_pct = (roll == 0) ? 20 : (roll == 1) ? 50 : 80;
      end
      word = $urandom();
      key  = word[KEY_W-1:0];
      roll = $urandom_range(0, 99);
      op   = ($urandom_range(0, 99) < append_pct) ? OP_APPEND : OP_DELETE;
      if (op == OP_APPEND) begin
        if (roll < 25) key = KEY_W'($urandom_range(0, 7));
        recent_keys.push_back(key);
        if (recent_keys.size() > LIST_DEPTH) recent_keys.pop_front();
      end else if (roll < 70 && recent_keys.size() > 0) begin
        idx = $urandom_range(0, recent_keys.size() - 1);
        key = recent_keys[idx];
        recent_keys.delete(idx);
      end else if (roll < 85) begin
        key = KEY_W'($urandom_range(0, 7));
      end
      queue_item(op, key, (n == 0 || n == 400));
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("** compact_list_append_delete_unit: PASSED **");
    end else begin
      $display("** compact_list_append_delete_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> compact_list_append_delete_unit.f
hdl/clad_pkg.sv
hdl/clad_cell.sv
hdl/compact_list_append_delete_unit.sv
sim/compact_list_append_delete_unit_tb.sv
